// File: rtl/core/uas_pkg.sv
// Shared widths, defaults and codes for the undirected adjacency store.
package uas_pkg;

  localparam int MaxVertices = 64;
  localparam int MaxDegree   = 32;

  localparam int VertexW  = 6;
  localparam int ActionW  = 2;
  localparam int StatusW  = 2;
  localparam int NumVertW = 7;

  localparam logic [NumVertW-1:0] NumVertRst = NumVertW'(64);

  localparam logic [ActionW-1:0] ACT_ADD  = 2'd0;
  localparam logic [ActionW-1:0] ACT_DEG  = 2'd1;
  localparam logic [ActionW-1:0] ACT_LIST = 2'd2;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_RANGE = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd3;

endpackage

// File: rtl/core/undirected_adjacency_store.sv
// Undirected adjacency store: per-vertex neighbor lists held in two memories.
//
// Holds an undirected graph as one bounded neighbor list per vertex, a degree
// memory of MAX_VERTICES counts and a neighbor memory of MAX_VERTICES *
// MAX_DEGREE entries, each with a read and a write port, walked by a small
// sequencer. After reset the block first zeroes the degree memory, one vertex
// per cycle; in_ready_o stays low meanwhile. An add-edge beat reads both
// degrees and, unless a list is full, appends to both lists; a degree query
// reads one degree; an out-of-range beat goes straight to the output; a list
// query reads the degree and then the neighbors, since each neighbor is one
// registered read of the neighbor memory. A result waits for the output
// register to free up. Every result waits in the output register until taken;
// a new beat may enter while one is pending.
module undirected_adjacency_store #(
  parameter int MAX_VERTICES = uas_pkg::MaxVertices,
  parameter int MAX_DEGREE   = uas_pkg::MaxDegree
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [uas_pkg::NumVertW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [uas_pkg::ActionW-1:0]   action_i,
  input  logic [uas_pkg::VertexW-1:0]   first_vertex_i,
  input  logic [uas_pkg::VertexW-1:0]   second_vertex_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [uas_pkg::VertexW-1:0]   value_o,
  output logic [uas_pkg::StatusW-1:0]   status_o,
  output logic                          last_o
);

  import uas_pkg::*;

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_DEGREE + 1);
  localparam int AW = (MAX_VERTICES * MAX_DEGREE > 1) ? $clog2(MAX_VERTICES * MAX_DEGREE) : 1;
  localparam int NbDepth = MAX_VERTICES * MAX_DEGREE;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RDA  = 4'd2;
  localparam logic [3:0] S_RDB  = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_WRB  = 4'd5;
  localparam logic [3:0] S_LRD  = 4'd6;
  localparam logic [3:0] S_LOUT = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  logic [3:0]          state_q, state_d;
  logic [VW-1:0]       clr_addr_q;
  logic [NumVertW-1:0] num_vert_q;

  logic [ActionW-1:0]  act_q;
  logic [VertexW-1:0]  a_q, b_q;
  logic [CW-1:0]       cnt_a_q, cnt_b_q, idx_q;
  logic [VertexW-1:0]  res_value_q;
  logic [StatusW-1:0]  res_status_q;

  logic                out_valid_q, last_q;
  logic [VertexW-1:0]  value_q;
  logic [StatusW-1:0]  status_q;

  logic [CW-1:0]       deg_mem [MAX_VERTICES];
  logic [CW-1:0]       deg_rd_q;
  logic [VertexW-1:0]  nb_mem [NbDepth];
  logic [VertexW-1:0]  nb_rd_q;

  logic                in_acc, out_free;
  logic                a_ok, b_ok, self_loop, full;
  logic [VW-1:0]       a_idx, b_idx, deg_raddr, deg_waddr;
  logic                deg_we;
  logic [CW-1:0]       deg_wdata;
  logic [AW-1:0]       base_a, base_b, nb_raddr, nb_waddr;
  logic                nb_we;
  logic [VertexW-1:0]  nb_wdata;
  logic                out_load;
  logic [VertexW-1:0]  out_value;
  logic [StatusW-1:0]  out_status;
  logic                out_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign a_ok = ({1'b0, first_vertex_i} < num_vert_q) && (32'(first_vertex_i) < MAX_VERTICES);
  assign b_ok = ({1'b0, second_vertex_i} < num_vert_q) &&
                (32'(second_vertex_i) < MAX_VERTICES);

  assign a_idx  = VW'(a_q);
  assign b_idx  = VW'(b_q);
  assign base_a = AW'(AW'(a_idx) * AW'(MAX_DEGREE));
  assign base_b = AW'(AW'(b_idx) * AW'(MAX_DEGREE));

  assign self_loop = (a_q == b_q);
  always_comb begin
    if (self_loop) begin
      full = ({1'b0, cnt_a_q} + (CW+1)'(2)) > (CW+1)'(MAX_DEGREE);
    end else begin
      full = (cnt_a_q >= CW'(MAX_DEGREE)) || (deg_rd_q >= CW'(MAX_DEGREE));
    end
  end

  // Degree memory port mux.
  assign deg_raddr = (state_q == S_RDA) ? a_idx : b_idx;
  always_comb begin
    deg_we    = 1'b0;
    deg_waddr = a_idx;
    deg_wdata = cnt_a_q + CW'(1);
    case (state_q)
      S_CLR: begin
        deg_we    = 1'b1;
        deg_waddr = clr_addr_q;
        deg_wdata = '0;
      end
      S_CHK: begin
        deg_we = !full;
      end
      S_WRB: begin
        deg_we    = 1'b1;
        deg_waddr = b_idx;
        deg_wdata = cnt_b_q + CW'(1);
      end
      default: begin
        deg_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    deg_rd_q <= deg_mem[deg_raddr];
  end

  // Neighbor memory port mux.
  assign nb_raddr = base_a + AW'(idx_q - CW'(1));
  assign nb_we    = ((state_q == S_CHK) && !full) || (state_q == S_WRB);
  assign nb_waddr = (state_q == S_CHK) ? (base_a + AW'(cnt_a_q)) : (base_b + AW'(cnt_b_q));
  assign nb_wdata = (state_q == S_CHK) ? b_q : a_q;

  always_ff @(posedge clk_i) begin
    if (nb_we) begin
      nb_mem[nb_waddr] <= nb_wdata;
    end
    nb_rd_q <= nb_mem[nb_raddr];
  end

  always_comb begin
    state_d    = state_q;
    out_load   = 1'b0;
    out_value  = res_value_q;
    out_status = res_status_q;
    out_last   = 1'b1;
    case (state_q)
      S_CLR: begin
        if (clr_addr_q == VW'(MAX_VERTICES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (action_i == ACT_ADD) begin
            state_d = (a_ok && b_ok) ? S_RDA : S_EMIT;
          end else if (action_i == ACT_DEG || action_i == ACT_LIST) begin
            state_d = a_ok ? S_RDA : S_EMIT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_RDA: begin
        state_d = S_RDB;
      end
      S_RDB: begin
        if (act_q == ACT_ADD) begin
          state_d = S_CHK;
        end else if (act_q == ACT_DEG) begin
          state_d = S_EMIT;
        end else if (deg_rd_q == '0) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_LRD;
        end
      end
      S_CHK: begin
        state_d = full ? S_EMIT : S_WRB;
      end
      S_WRB: begin
        state_d = S_IDLE;
      end
      S_LRD: begin
        state_d = S_LOUT;
      end
      S_LOUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_value  = nb_rd_q;
          out_status = ST_OK;
          out_last   = (idx_q == CW'(1));
          state_d    = (idx_q == CW'(1)) ? S_IDLE : S_LRD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_addr_q  <= '0;
      num_vert_q  <= NumVertRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) begin
        clr_addr_q <= clr_addr_q + VW'(1);
      end
      if (cfg_we_i) begin
        num_vert_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q        <= action_i;
      a_q          <= first_vertex_i;
      b_q          <= second_vertex_i;
      res_value_q  <= '0;
      res_status_q <= ST_RANGE;
    end
    if (state_q == S_RDB) begin
      cnt_a_q <= deg_rd_q;
      idx_q   <= deg_rd_q;
      if (act_q == ACT_DEG) begin
        res_value_q  <= VertexW'(deg_rd_q);
        res_status_q <= (deg_rd_q == '0) ? ST_EMPTY : ST_OK;
      end
    end
    if (state_q == S_CHK) begin
      cnt_b_q      <= self_loop ? (cnt_a_q + CW'(1)) : deg_rd_q;
      res_value_q  <= '0;
      res_status_q <= ST_FULL;
    end
    if (state_q == S_LOUT && out_free) begin
      idx_q <= idx_q - CW'(1);
    end
    if (out_load) begin
      value_q  <= out_value;
      status_q <= out_status;
      last_q   <= out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !in_ready_o)
    else $error("beat accepted during degree clear");

  a_deg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deg_we |-> ({1'b0, deg_wdata} <= (CW+1)'(MAX_DEGREE)))
    else $error("degree count above bound");

  a_list_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LRD || state_q == S_LOUT) |-> (idx_q != '0))
    else $error("list walk with zero index");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_RANGE || status_o == ST_FULL || status_o == ST_EMPTY))
      |-> (last_o && value_o == '0))
    else $error("error beat not final or nonzero");

endmodule
